### rtl/core/sensor_record_normalizer_macros.svh
// Assertion macros shared by the sensor record normalizer checkers.
`ifndef SENSOR_RECORD_NORMALIZER_MACROS_SVH
`define SENSOR_RECORD_NORMALIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRN_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sensor record normalizer: implication check failed");

// Next-cycle implication, disabled during reset.
`define SRN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sensor record normalizer: next-cycle check failed");

`endif

### rtl/core/srn_pkg.sv
// Shared types and constants of the sensor record normalizer.
`timescale 1ns / 1ps
package srn_pkg;

   localparam int AdcW = 12;
   localparam logic [13:0] FullPct = 14'd10000;
   localparam logic [13:0] VpdMax = 14'd10000;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_SOIL_DRY    = 3'd0,
      CSR_SOIL_WET    = 3'd1,
      CSR_WATER_EMPTY = 3'd2,
      CSR_WATER_FULL  = 3'd3,
      CSR_WATER_MODE  = 3'd4,
      CSR_SAFE_MIN    = 3'd5
   } srn_csr_type;

   // How a level result is formed.
   typedef enum logic [1:0] {
      LVL_ZERO = 2'd0,
      LVL_FULL = 2'd1,
      LVL_DIV  = 2'd2
   } srn_lvl_type;

   typedef struct packed {
      logic [AdcW-1:0] soil_dry;
      logic [AdcW-1:0] soil_wet;
      logic [AdcW-1:0] water_empty;
      logic [AdcW-1:0] water_full;
      logic            water_mode;
   } srn_cfg_type;

   // One classified record, as queued between front and back.
   typedef struct packed {
      srn_lvl_type        soil_mode;
      logic [AdcW-1:0]    soil_num;
      logic [AdcW-1:0]    soil_den;
      srn_lvl_type        water_mode;
      logic [AdcW-1:0]    water_num;
      logic [AdcW-1:0]    water_den;
      logic               soil_ok;
      logic signed [14:0] soil_temp;
      logic               soil_temp_ok;
      logic signed [14:0] amb_temp;
      logic [13:0]        amb_hum;
      logic               amb_ok;
      logic [15:0]        light;
      logic               light_ok;
   } srn_job_type;

endpackage

### rtl/core/srn_front.sv
// Front end: range checks and level classification of one input beat.
`timescale 1ns / 1ps
module srn_front #(
   parameter int ADC_BITS = 12
) (
   input  srn_pkg::srn_cfg_type cfg,
   input  logic [11:0]          req_soil_raw,
   input  logic [11:0]          req_water_raw,
   input  logic                 req_water_switch,
   input  logic signed [15:0]   req_probe_temp,
   input  logic signed [15:0]   req_air_temp,
   input  logic signed [15:0]   req_air_humidity,
   input  logic signed [16:0]   req_light_level,
   output srn_pkg::srn_job_type job
);
   import srn_pkg::*;

   localparam logic [AdcW-1:0] AdcMask =
      (ADC_BITS >= AdcW) ? {AdcW{1'b1}} : AdcW'((1 << ADC_BITS) - 1);

   logic [AdcW-1:0] soil_hi, soil_lo, soil_m;
   logic [AdcW-1:0] water_hi, water_lo, water_m;
   logic            amb_ok;

   always_comb begin
      soil_hi  = cfg.soil_dry & AdcMask;
      soil_lo  = cfg.soil_wet & AdcMask;
      soil_m   = req_soil_raw & AdcMask;
      water_hi = cfg.water_full & AdcMask;
      water_lo = cfg.water_empty & AdcMask;
      water_m  = req_water_raw & AdcMask;

      // Soil: dry reads high, so the distance is measured down from dry.
      job.soil_num = soil_hi - soil_m;
      job.soil_den = soil_hi - soil_lo;
      if (soil_hi <= soil_lo || soil_hi <= soil_m) begin
         job.soil_mode = LVL_ZERO;
      end else if (job.soil_num >= job.soil_den) begin
         job.soil_mode = LVL_FULL;
      end else begin
         job.soil_mode = LVL_DIV;
      end

      // Water: float switch or forward calibration.
      job.water_num = water_m - water_lo;
      job.water_den = water_hi - water_lo;
      if (cfg.water_mode) begin
         job.water_mode = req_water_switch ? LVL_FULL : LVL_ZERO;
      end else if (water_hi <= water_lo || water_m <= water_lo) begin
         job.water_mode = LVL_ZERO;
      end else if (job.water_num >= job.water_den) begin
         job.water_mode = LVL_FULL;
      end else begin
         job.water_mode = LVL_DIV;
      end

      job.soil_ok = (soil_m > 12'd100) && (soil_m < 12'd4090);

      // Probe temperature, which also rejects the disconnected code.
      job.soil_temp_ok = (req_probe_temp > -16'sd5500) && (req_probe_temp < 16'sd12500);
      job.soil_temp    = job.soil_temp_ok ? 15'(req_probe_temp) : 15'sd2500;

      amb_ok = (req_air_temp > -16'sd4000) && (req_air_temp < 16'sd8500) &&
               (req_air_humidity >= 16'sd0) && (req_air_humidity <= 16'sd10000);
      job.amb_ok   = amb_ok;
      job.amb_temp = amb_ok ? 15'(req_air_temp) : 15'sd2500;
      job.amb_hum  = amb_ok ? 14'(req_air_humidity) : 14'd7500;

      job.light_ok = !req_light_level[16];
      job.light    = job.light_ok ? req_light_level[15:0] : 16'd0;
   end

endmodule

### rtl/core/srn_fifo.sv
// Short queue of classified records between the front and back ends.
`timescale 1ns / 1ps
module srn_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  srn_pkg::srn_job_type push_data,
   output logic                 full,
   input  logic                 pop,
   output srn_pkg::srn_job_type pop_data,
   output logic                 not_empty
);
   import srn_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   srn_job_type         entries_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]     count_ff;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            count_ff <= CntW'(count_ff + 1'b1);
         end else if (pop && !push) begin
            count_ff <= CntW'(count_ff - 1'b1);
         end
      end
   end

endmodule

### rtl/core/srn_div.sv
// Restoring divider for a calibrated level: floor(num * 10000 / den), num < den.
`timescale 1ns / 1ps
module srn_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [11:0] num,
   input  logic [11:0] den,
   output logic        busy,
   output logic [13:0] quot
);
   import srn_pkg::*;

   logic        busy_ff;
   logic [3:0]  step_ff;
   logic [25:0] rem_ff;
   logic [11:0] den_ff;
   logic [13:0] quot_ff;
   logic [25:0] trial;

   assign busy  = busy_ff;
   assign quot  = quot_ff;
   assign trial = 26'(den_ff) << step_ff;

   // One quotient bit per cycle, most significant first.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && step_ff == 4'd0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= 26'(num) * 26'(FullPct);
         den_ff  <= den;
         quot_ff <= '0;
         step_ff <= 4'd13;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_ff           <= rem_ff - trial;
            quot_ff[step_ff] <= 1'b1;
         end
         step_ff <= step_ff - 4'd1;
      end
   end

endmodule

### rtl/core/srn_back.sv
// Back end: level division, saturation table interpolation and the result register.
`timescale 1ns / 1ps
module srn_back #(
   parameter int SAT_TABLE_ENTRIES = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  srn_pkg::srn_job_type job_data,
   output logic                 job_pop,
   input  logic [13:0]          safe_min,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [13:0]          rsp_soil_moisture_pct,
   output logic                 rsp_soil_ok,
   output logic [13:0]          rsp_water_level_pct,
   output logic                 rsp_reservoir_safe,
   output logic signed [14:0]   rsp_soil_temp,
   output logic                 rsp_soil_temp_ok,
   output logic signed [14:0]   rsp_ambient_temp,
   output logic [13:0]          rsp_ambient_humidity,
   output logic                 rsp_ambient_ok,
   output logic [13:0]          rsp_vapour_deficit,
   output logic [15:0]          rsp_light_out,
   output logic                 rsp_light_ok
);
   import srn_pkg::*;

   localparam int IdxW = $clog2(SAT_TABLE_ENTRIES);
   localparam int PosW = IdxW + 14;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(SAT_TABLE_ENTRIES - 1);
   localparam logic [13:0] SegSpan = 14'd12000;
   localparam logic [30:0] Recip12k = 31'(((64'd1 << 44) + 64'd11999) / 64'd12000);
   localparam logic [30:0] Recip10k = 31'(((64'd1 << 44) + 64'd9999) / 64'd10000);
   localparam longint Q24 = 64'sd16777216;
   localparam longint Steps = SAT_TABLE_ENTRIES - 1;

   // Saturation pressure table, 0.001 kPa, -40 to 80 degC.
   logic [15:0] sat_tab [SAT_TABLE_ENTRIES];

   for (genvar g = 0; g < SAT_TABLE_ENTRIES; g++) begin : g_tab
      localparam longint Pt  = -64'sd4000 * Steps + 64'sd12000 * longint'(g);
      localparam longint Num = 64'sd1727 * Pt * Q24;
      localparam longint Den = 64'sd1600 * (Pt + 64'sd23730 * Steps);
      localparam longint H   = Num / Den;
      localparam longint T2  = H * H / Q24;
      localparam longint T3  = T2 * H / Q24;
      localparam longint T4  = T3 * H / Q24;
      localparam longint T5  = T4 * H / Q24;
      localparam longint Ex  = Q24 + H + T2 / 2 + T3 / 6 + T4 / 24 + T5 / 120;
      localparam longint unsigned U0 = longint'(Ex);
      localparam longint unsigned U1 = (U0 * U0) >> 24;
      localparam longint unsigned U2 = (U1 * U1) >> 24;
      localparam longint unsigned U3 = (U2 * U2) >> 24;
      localparam longint unsigned U4 = (U3 * U3) >> 24;
      localparam logic [15:0] Val =
         16'((64'd61078 * U4 + 64'd50 * 64'd16777216) / (64'd100 * 64'd16777216));
      assign sat_tab[g] = Val;
   end

   typedef enum logic [3:0] {
      S_IDLE, S_POS, S_IDX, S_FRAC, S_READ, S_DIFF, S_DIV1,
      S_ES, S_RH, S_DIV2, S_VPD, S_DONE
   } state_type;

   state_type          state_ff;
   srn_job_type        job_ff;
   logic               in_range_ff;
   logic [PosW-1:0]    pos_ff;
   logic [60:0]        prod_ff;
   logic [IdxW-1:0]    idx_ff;
   logic [13:0]        frac_ff;
   logic [15:0]        tab_lo_ff, tab_hi_ff, es_ff;
   logic [13:0]        vpd_ff;

   logic               rsp_valid_ff;
   logic [13:0]        soil_pct_ff, water_pct_ff, amb_hum_ff, vpd_out_ff;
   logic               soil_ok_ff, safe_ff, soil_temp_ok_ff, amb_ok_ff, light_ok_ff;
   logic signed [14:0] soil_temp_ff, amb_temp_ff;
   logic [15:0]        light_ff;

   logic               soil_busy, water_busy;
   logic [13:0]        soil_quot, water_quot;
   logic               div_start;

   logic signed [15:0] t_off;
   logic [PosW-1:0]    idx_scaled;
   logic [IdxW-1:0]    hi_idx;
   logic [15:0]        tab_diff;
   logic [29:0]        interp_mul, rh_mul;
   logic [60:0]        div12_mul, div10_mul;
   logic [15:0]        vpd_q;
   logic [13:0]        soil_pct, water_pct;
   logic               out_free;
   logic               out_fire;

   // The fifo head is taken whenever the sequencer is free.
   assign div_start = (state_ff == S_IDLE) && job_valid;
   assign job_pop   = div_start;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_fire  = (state_ff == S_DONE) && !soil_busy && !water_busy && out_free;

   srn_div u_soil_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (job_data.soil_num),
      .den   (job_data.soil_den),
      .busy  (soil_busy),
      .quot  (soil_quot)
   );

   srn_div u_water_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (job_data.water_num),
      .den   (job_data.water_den),
      .busy  (water_busy),
      .quot  (water_quot)
   );

   // Datapath terms, one multiply per sequencer step.
   always_comb begin
      t_off      = 16'(job_ff.amb_temp) + 16'sd4000;
      idx_scaled = PosW'(idx_ff) * PosW'(SegSpan);
      hi_idx     = (idx_ff == LastIdx) ? idx_ff : IdxW'(idx_ff + 1'b1);
      tab_diff   = tab_hi_ff - tab_lo_ff;
      interp_mul = tab_diff * frac_ff;
      rh_mul     = es_ff * (FullPct - job_ff.amb_hum);
      div12_mul  = prod_ff[29:0] * Recip12k;
      div10_mul  = prod_ff[29:0] * Recip10k;
      vpd_q      = prod_ff[44 +: 16];

      case (job_ff.soil_mode)
         LVL_FULL: soil_pct = FullPct;
         LVL_DIV:  soil_pct = soil_quot;
         default:  soil_pct = 14'd0;
      endcase
      case (job_ff.water_mode)
         LVL_FULL: water_pct = FullPct;
         LVL_DIV:  water_pct = water_quot;
         default:  water_pct = 14'd0;
      endcase
   end

   // Sequencer with the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result beat replaces the one leaving in the same cycle.
         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job_data;
                  state_ff <= S_POS;
               end
            end
            S_POS: begin
               in_range_ff <= (job_ff.amb_temp >= -15'sd4000) &&
                              (job_ff.amb_temp <= 15'sd8000);
               pos_ff      <= PosW'(t_off[13:0]) * PosW'(SAT_TABLE_ENTRIES - 1);
               state_ff    <= S_IDX;
            end
            S_IDX: begin
               prod_ff  <= 61'(pos_ff) * 61'(Recip12k);
               state_ff <= S_FRAC;
            end
            S_FRAC: begin
               idx_ff   <= prod_ff[44 +: IdxW];
               state_ff <= S_READ;
            end
            S_READ: begin
               frac_ff   <= 14'(pos_ff - idx_scaled);
               tab_lo_ff <= sat_tab[idx_ff];
               tab_hi_ff <= sat_tab[hi_idx];
               state_ff  <= S_DIFF;
            end
            S_DIFF: begin
               prod_ff  <= 61'(interp_mul);
               state_ff <= S_DIV1;
            end
            S_DIV1: begin
               prod_ff  <= div12_mul;
               state_ff <= S_ES;
            end
            S_ES: begin
               es_ff    <= tab_lo_ff + prod_ff[44 +: 16];
               state_ff <= S_RH;
            end
            S_RH: begin
               prod_ff  <= 61'(rh_mul);
               state_ff <= S_DIV2;
            end
            S_DIV2: begin
               prod_ff  <= div10_mul;
               state_ff <= S_VPD;
            end
            S_VPD: begin
               if (!in_range_ff) begin
                  vpd_ff <= 14'd0;
               end else if (vpd_q > 16'(VpdMax)) begin
                  vpd_ff <= VpdMax;
               end else begin
                  vpd_ff <= 14'(vpd_q);
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_fire) begin
                  soil_pct_ff     <= soil_pct;
                  soil_ok_ff      <= job_ff.soil_ok;
                  water_pct_ff    <= water_pct;
                  safe_ff         <= (water_pct >= safe_min);
                  soil_temp_ff    <= job_ff.soil_temp;
                  soil_temp_ok_ff <= job_ff.soil_temp_ok;
                  amb_temp_ff     <= job_ff.amb_temp;
                  amb_hum_ff      <= job_ff.amb_hum;
                  amb_ok_ff       <= job_ff.amb_ok;
                  vpd_out_ff      <= vpd_ff;
                  light_ff        <= job_ff.light;
                  light_ok_ff     <= job_ff.light_ok;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_soil_moisture_pct = soil_pct_ff;
   assign rsp_soil_ok           = soil_ok_ff;
   assign rsp_water_level_pct   = water_pct_ff;
   assign rsp_reservoir_safe    = safe_ff;
   assign rsp_soil_temp         = soil_temp_ff;
   assign rsp_soil_temp_ok      = soil_temp_ok_ff;
   assign rsp_ambient_temp      = amb_temp_ff;
   assign rsp_ambient_humidity  = amb_hum_ff;
   assign rsp_ambient_ok        = amb_ok_ff;
   assign rsp_vapour_deficit    = vpd_out_ff;
   assign rsp_light_out         = light_ff;
   assign rsp_light_ok          = light_ok_ff;

endmodule

### rtl/core/sensor_record_normalizer.sv
// The back end works on one record at a time, through the 14-step level dividers, and takes
// the next record only after the result beat of the last one has been issued.
// Input beats keep being taken into a two-entry queue while the back end works, until it fills.
// Reset is synchronous and active high; it clears control state and loads register defaults.
// The saturation table is constant logic, so there is no fill or clearing pass after reset.
`timescale 1ns / 1ps
module sensor_record_normalizer #(
   parameter int ADC_BITS          = 12,
   parameter int SAT_TABLE_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_soil_raw,
   input  logic [11:0]        req_water_raw,
   input  logic               req_water_switch,
   input  logic signed [15:0] req_probe_temp,
   input  logic signed [15:0] req_air_temp,
   input  logic signed [15:0] req_air_humidity,
   input  logic signed [16:0] req_light_level,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        rsp_soil_moisture_pct,
   output logic               rsp_soil_ok,
   output logic [13:0]        rsp_water_level_pct,
   output logic               rsp_reservoir_safe,
   output logic signed [14:0] rsp_soil_temp,
   output logic               rsp_soil_temp_ok,
   output logic signed [14:0] rsp_ambient_temp,
   output logic [13:0]        rsp_ambient_humidity,
   output logic               rsp_ambient_ok,
   output logic [13:0]        rsp_vapour_deficit,
   output logic [15:0]        rsp_light_out,
   output logic               rsp_light_ok,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import srn_pkg::*;

   srn_cfg_type cfg_ff;
   logic [13:0] safe_min_ff;
   srn_job_type front_job, head_job;
   logic        fifo_full, fifo_not_empty, job_pop, push;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.soil_dry    <= 12'd3000;
         cfg_ff.soil_wet    <= 12'd1300;
         cfg_ff.water_empty <= 12'd0;
         cfg_ff.water_full  <= 12'd4095;
         cfg_ff.water_mode  <= 1'b0;
         safe_min_ff        <= 14'd2000;
      end else if (csr_valid) begin
         unique case (srn_csr_type'(csr_index))
            CSR_SOIL_DRY:    cfg_ff.soil_dry    <= csr_data[11:0];
            CSR_SOIL_WET:    cfg_ff.soil_wet    <= csr_data[11:0];
            CSR_WATER_EMPTY: cfg_ff.water_empty <= csr_data[11:0];
            CSR_WATER_FULL:  cfg_ff.water_full  <= csr_data[11:0];
            CSR_WATER_MODE:  cfg_ff.water_mode  <= csr_data[0];
            CSR_SAFE_MIN:    safe_min_ff        <= csr_data[13:0];
            default: ;
         endcase
      end
   end

   assign req_stall = fifo_full;
   assign push      = req_valid && !fifo_full;

   srn_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .cfg              (cfg_ff),
      .req_soil_raw     (req_soil_raw),
      .req_water_raw    (req_water_raw),
      .req_water_switch (req_water_switch),
      .req_probe_temp   (req_probe_temp),
      .req_air_temp     (req_air_temp),
      .req_air_humidity (req_air_humidity),
      .req_light_level  (req_light_level),
      .job              (front_job)
   );

   srn_fifo #(
      .DEPTH (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_job),
      .full      (fifo_full),
      .pop       (job_pop),
      .pop_data  (head_job),
      .not_empty (fifo_not_empty)
   );

   srn_back #(
      .SAT_TABLE_ENTRIES (SAT_TABLE_ENTRIES)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .job_valid             (fifo_not_empty),
      .job_data              (head_job),
      .job_pop               (job_pop),
      .safe_min              (safe_min_ff),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_soil_moisture_pct (rsp_soil_moisture_pct),
      .rsp_soil_ok           (rsp_soil_ok),
      .rsp_water_level_pct   (rsp_water_level_pct),
      .rsp_reservoir_safe    (rsp_reservoir_safe),
      .rsp_soil_temp         (rsp_soil_temp),
      .rsp_soil_temp_ok      (rsp_soil_temp_ok),
      .rsp_ambient_temp      (rsp_ambient_temp),
      .rsp_ambient_humidity  (rsp_ambient_humidity),
      .rsp_ambient_ok        (rsp_ambient_ok),
      .rsp_vapour_deficit    (rsp_vapour_deficit),
      .rsp_light_out         (rsp_light_out),
      .rsp_light_ok          (rsp_light_ok)
   );

endmodule

### rtl/core/srn_checker.sv
// Port-level assertions for the sensor record normalizer, bound to the top level.
`timescale 1ns / 1ps
`include "sensor_record_normalizer_macros.svh"
module srn_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [13:0]        rsp_soil_moisture_pct,
   input logic [13:0]        rsp_water_level_pct,
   input logic signed [14:0] rsp_soil_temp,
   input logic               rsp_soil_temp_ok,
   input logic signed [14:0] rsp_ambient_temp,
   input logic [13:0]        rsp_ambient_humidity,
   input logic               rsp_ambient_ok,
   input logic [13:0]        rsp_vapour_deficit,
   input logic [15:0]        rsp_light_out,
   input logic               rsp_light_ok
);

   // A stalled result beat stays put.
   `SRN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_soil_moisture_pct) && $stable(rsp_vapour_deficit))

   // Failed checks carry their default values.
   `SRN_ASSERT_IMPL(a_amb_default, clock, reset, rsp_valid && !rsp_ambient_ok, rsp_ambient_temp == 15'sd2500 && rsp_ambient_humidity == 14'd7500)
   `SRN_ASSERT_IMPL(a_probe_default, clock, reset, rsp_valid && !rsp_soil_temp_ok, rsp_soil_temp == 15'sd2500)
   `SRN_ASSERT_IMPL(a_light_zero, clock, reset, rsp_valid && !rsp_light_ok, rsp_light_out == 16'd0)

   // Levels and deficit never leave their clamp range.
   `SRN_ASSERT_IMPL(a_clamp, clock, reset, rsp_valid, rsp_soil_moisture_pct <= 14'd10000 && rsp_water_level_pct <= 14'd10000 && rsp_vapour_deficit <= 14'd10000)

endmodule

bind sensor_record_normalizer srn_checker u_srn_checker (.*);
